/* src/fes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_pkg: shared types and constants of the FLV tag to elementary stream block
// Store sizes, queue command format, configuration codes and FLV codes.
// ----------------------------------------------------------------------------
package fes_pkg;

    localparam int SPS_BYTES = 32;
    localparam int PPS_BYTES = 16;

    localparam int SPS_AW = $clog2(SPS_BYTES);
    localparam int PPS_AW = $clog2(PPS_BYTES);
    localparam int SPS_LW = $clog2(SPS_BYTES + 1);
    localparam int PPS_LW = $clog2(PPS_BYTES + 1);
    localparam int CNT_W0 = (SPS_AW > PPS_AW) ? SPS_AW : PPS_AW;
    localparam int CNT_W  = (CNT_W0 > 3) ? CNT_W0 : 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] REG_PROFILE    = 2'd0;
    localparam logic [1:0] REG_RATE_INDEX = 2'd1;
    localparam logic [1:0] REG_CHANNELS   = 2'd2;

    // FLV codes.
    localparam logic [7:0] TAG_VIDEO = 8'h09;
    localparam logic [7:0] TAG_AUDIO = 8'h08;
    localparam logic [3:0] CODEC_AVC = 4'h7;
    localparam logic [3:0] SOUND_AAC = 4'ha;
    localparam logic [3:0] FRAME_KEY = 4'h1;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_START,
        CMD_SETS,
        CMD_ADTS,
        CMD_SPS_WR,
        CMD_PPS_WR,
        CMD_SPS_CLR,
        CMD_PPS_CLR
    } cmd_kind_t;

    // data holds a byte in [7:0] and a store address in [15:8], or the ADTS
    // frame length in [12:0].
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;
        logic        last;
        logic        audio;
        logic        key;
        logic        ovf;
    } cmd_t;

    typedef struct packed {
        logic [1:0] profile;
        logic [3:0] rate_index;
        logic [2:0] channels;
    } adts_cfg_t;

endpackage

/* src/fes_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_if: channel interfaces
// Tag byte input, elementary stream output and configuration write channel.
// ----------------------------------------------------------------------------
interface fes_tag_if;
    logic       valid;
    logic       ready;
    logic [7:0] tag_byte;
    logic       tag_last;
    modport source (output valid, output tag_byte, output tag_last, input ready);
    modport sink (input valid, input tag_byte, input tag_last, output ready);
endinterface

interface fes_es_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_last;
    logic       is_audio;
    logic       key_frame;
    logic       store_overflow;
    modport source (output valid, output out_byte, output frame_last, output is_audio,
                    output key_frame, output store_overflow, input ready);
    modport sink (input valid, input out_byte, input frame_last, input is_audio,
                  input key_frame, input store_overflow, output ready);
endinterface

interface fes_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/fes_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_front: FLV tag parser
// Parses one tag byte per transaction and issues up to two commands to the queue.
// ----------------------------------------------------------------------------
module fes_front
    import fes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       in_ready,
    input  logic       room2,
    output logic       push_a,
    output cmd_t       cmd_a,
    output logic       push_b,
    output cmd_t       cmd_b
);

    typedef enum logic [3:0] {
        PH_HDR, PH_VCODEC, PH_VPTYPE, PH_VCTS, PH_VCFG, PH_VNSPS, PH_VSPSLEN,
        PH_VSPSDATA, PH_VNPPS, PH_VPPSLEN, PH_VPPSDATA, PH_VNLEN, PH_PAYLOAD,
        PH_ACODEC, PH_APTYPE, PH_SKIP
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [3:0]        bc_reg, bc_next;
    logic [7:0]        kind_reg, kind_next;
    logic [23:0]       body_reg, body_next;
    logic [7:0]        codec_reg, codec_next;
    logic [7:0]        pk_reg, pk_next;
    logic [31:0]       nalu_reg, nalu_next;
    logic [7:0]        sr_reg, sr_next;
    logic [15:0]       sl_reg, sl_next;
    logic [SPS_LW-1:0] sps_cnt_reg, sps_cnt_next;
    logic [PPS_LW-1:0] pps_cnt_reg, pps_cnt_next;
    logic              ovf_reg, ovf_next;

    logic        accept;
    logic        f_audio, f_key;
    logic [23:0] aac;
    logic [12:0] flen;

    assign in_ready = room2;
    assign accept   = in_valid && room2;

    always_comb
    begin
        cmd_t c0, c1;
        logic v0, v1;
        c0 = '0;
        c1 = '0;
        v0 = 1'b0;
        v1 = 1'b0;
        phase_next   = phase_reg;
        bc_next      = bc_reg;
        kind_next    = kind_reg;
        body_next    = body_reg;
        codec_next   = codec_reg;
        pk_next      = pk_reg;
        nalu_next    = nalu_reg;
        sr_next      = sr_reg;
        sl_next      = sl_reg;
        sps_cnt_next = sps_cnt_reg;
        pps_cnt_next = pps_cnt_reg;
        ovf_next     = ovf_reg;
        aac          = (body_reg >= 24'd2) ? body_reg - 24'd2 : 24'd0;
        flen         = aac[12:0] + 13'd7;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR:
                begin
                    if (bc_reg == 4'd0)
                        kind_next = in_byte;
                    else if (bc_reg <= 4'd3)
                        body_next = {body_reg[15:0], in_byte};
                    bc_next = bc_reg + 4'd1;
                    if (bc_reg == 4'd10)
                    begin
                        bc_next = 4'd0;
                        phase_next = (kind_next == TAG_VIDEO) ? PH_VCODEC :
                                     (kind_next == TAG_AUDIO) ? PH_ACODEC : PH_SKIP;
                    end
                end
                PH_VCODEC:
                begin
                    codec_next = in_byte;
                    phase_next = (in_byte[3:0] == CODEC_AVC) ? PH_VPTYPE : PH_SKIP;
                end
                PH_VPTYPE:
                begin
                    pk_next = in_byte;
                    bc_next = 4'd0;
                    phase_next = PH_VCTS;
                end
                PH_VCTS:
                begin
                    bc_next = bc_reg + 4'd1;
                    if (bc_reg == 4'd2)
                    begin
                        bc_next = 4'd0;
                        nalu_next = '0;
                        if (codec_reg[7:4] == FRAME_KEY)
                            phase_next = (pk_reg == 8'd0) ? PH_VCFG :
                                         (pk_reg == 8'd1) ? PH_VNLEN : PH_SKIP;
                        else
                            phase_next = PH_VNLEN;
                    end
                end
                PH_VCFG:
                begin
                    bc_next = bc_reg + 4'd1;
                    if (bc_reg == 4'd4)
                        phase_next = PH_VNSPS;
                end
                PH_VNSPS:
                begin
                    sr_next = {3'b000, in_byte[4:0]};
                    sps_cnt_next = '0;
                    ovf_next = 1'b0;
                    bc_next = 4'd0;
                    v0 = 1'b1;
                    c0.kind = CMD_SPS_CLR;
                    phase_next = (in_byte[4:0] != 5'd0) ? PH_VSPSLEN : PH_VNPPS;
                end
                PH_VSPSLEN, PH_VPPSLEN:
                begin
                    sl_next = {sl_reg[7:0], in_byte};
                    bc_next = bc_reg + 4'd1;
                    if (bc_reg == 4'd1)
                    begin
                        if (sl_next != 16'd0)
                            phase_next = (phase_reg == PH_VSPSLEN) ? PH_VSPSDATA
                                                                   : PH_VPPSDATA;
                        else
                        begin
                            sr_next = sr_reg - 8'd1;
                            bc_next = 4'd0;
                            if (phase_reg == PH_VSPSLEN)
                                phase_next = (sr_next != 8'd0) ? PH_VSPSLEN : PH_VNPPS;
                            else if (sr_next != 8'd0)
                                phase_next = PH_VPPSLEN;
                            else
                            begin
                                v0 = 1'b1;
                                c0.kind = CMD_SETS;
                                c0.last = 1'b1;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
                PH_VSPSDATA:
                begin
                    if (sps_cnt_reg < SPS_LW'(SPS_BYTES))
                    begin
                        v0 = 1'b1;
                        c0.kind = CMD_SPS_WR;
                        c0.data = {8'(sps_cnt_reg), in_byte};
                        sps_cnt_next = sps_cnt_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                    sl_next = sl_reg - 16'd1;
                    if (sl_next == 16'd0)
                    begin
                        sr_next = sr_reg - 8'd1;
                        bc_next = 4'd0;
                        phase_next = (sr_next != 8'd0) ? PH_VSPSLEN : PH_VNPPS;
                    end
                end
                PH_VNPPS:
                begin
                    pps_cnt_next = '0;
                    bc_next = 4'd0;
                    v0 = 1'b1;
                    c0.kind = CMD_PPS_CLR;
                    if (in_byte != 8'd0)
                    begin
                        sr_next = in_byte;
                        phase_next = PH_VPPSLEN;
                    end
                    else
                    begin
                        sr_next = 8'd0;
                        v1 = 1'b1;
                        c1.kind = CMD_SETS;
                        c1.last = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_VPPSDATA:
                begin
                    if (pps_cnt_reg < PPS_LW'(PPS_BYTES))
                    begin
                        v0 = 1'b1;
                        c0.kind = CMD_PPS_WR;
                        c0.data = {8'(pps_cnt_reg), in_byte};
                        pps_cnt_next = pps_cnt_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                    sl_next = sl_reg - 16'd1;
                    if (sl_next == 16'd0)
                    begin
                        sr_next = sr_reg - 8'd1;
                        bc_next = 4'd0;
                        if (sr_next != 8'd0)
                            phase_next = PH_VPPSLEN;
                        else
                        begin
                            // The set commands go out behind any store write.
                            if (v0)
                            begin
                                v1 = 1'b1;
                                c1.kind = CMD_SETS;
                                c1.last = 1'b1;
                            end
                            else
                            begin
                                v0 = 1'b1;
                                c0.kind = CMD_SETS;
                                c0.last = 1'b1;
                            end
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_VNLEN:
                begin
                    nalu_next = {nalu_reg[23:0], in_byte};
                    bc_next = bc_reg + 4'd1;
                    if (bc_reg == 4'd3)
                    begin
                        bc_next = 4'd0;
                        if (codec_reg[7:4] == FRAME_KEY)
                        begin
                            v0 = 1'b1;
                            c0.kind = CMD_SETS;
                            v1 = 1'b1;
                            c1.kind = CMD_START;
                            c1.last = (nalu_next == 32'd0) || in_last;
                        end
                        else
                        begin
                            v0 = 1'b1;
                            c0.kind = CMD_START;
                            c0.last = (nalu_next == 32'd0) || in_last;
                        end
                        phase_next = (nalu_next != 32'd0) ? PH_PAYLOAD : PH_SKIP;
                    end
                end
                PH_PAYLOAD:
                begin
                    nalu_next = nalu_reg - 32'd1;
                    v0 = 1'b1;
                    c0.kind = CMD_BYTE;
                    c0.data = {8'd0, in_byte};
                    c0.last = (nalu_next == 32'd0) || in_last;
                    if (nalu_next == 32'd0)
                        phase_next = PH_SKIP;
                end
                PH_ACODEC:
                begin
                    codec_next = in_byte;
                    phase_next = (in_byte[7:4] == SOUND_AAC) ? PH_APTYPE : PH_SKIP;
                end
                PH_APTYPE:
                begin
                    pk_next = in_byte;
                    v0 = 1'b1;
                    c0.kind = CMD_ADTS;
                    c0.data = {3'b000, flen};
                    c0.last = (aac == 24'd0) || in_last;
                    nalu_next = {8'd0, aac};
                    phase_next = (aac != 24'd0) ? PH_PAYLOAD : PH_SKIP;
                end
                PH_SKIP:
                begin
                    phase_next = PH_SKIP;
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
            if (in_last)
            begin
                phase_next = PH_HDR;
                bc_next = 4'd0;
            end
        end
        // Frame flags are taken after this byte's state update.
        f_audio = (kind_next == TAG_AUDIO);
        f_key   = !f_audio && (codec_next[7:4] == FRAME_KEY);
        c0.audio = f_audio;
        c0.key   = f_key;
        c0.ovf   = ovf_next;
        c1.audio = f_audio;
        c1.key   = f_key;
        c1.ovf   = ovf_next;
        push_a = v0;
        push_b = v1;
        cmd_a  = c0;
        cmd_b  = c1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR;
            bc_reg      <= '0;
            kind_reg    <= '0;
            body_reg    <= '0;
            codec_reg   <= '0;
            pk_reg      <= '0;
            nalu_reg    <= '0;
            sr_reg      <= '0;
            sl_reg      <= '0;
            sps_cnt_reg <= '0;
            pps_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            kind_reg    <= kind_next;
            body_reg    <= body_next;
            codec_reg   <= codec_next;
            pk_reg      <= pk_next;
            nalu_reg    <= nalu_next;
            sr_reg      <= sr_next;
            sl_reg      <= sl_next;
            sps_cnt_reg <= sps_cnt_next;
            pps_cnt_reg <= pps_cnt_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

/* src/fes_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_queue: command queue
// Small queue taking up to two commands a cycle and giving one.
// ----------------------------------------------------------------------------
module fes_queue
    import fes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_a,
    input  cmd_t cmd_a,
    input  logic push_b,
    input  cmd_t cmd_b,
    output logic room2,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    cmd_t            mem [QUEUE_DEPTH];
    logic [Q_AW-1:0] wr_reg, rd_reg;
    logic [Q_AW:0]   cnt_reg;
    logic [Q_AW-1:0] wr_b;
    logic            do_pop;

    assign wr_b       = wr_reg + 1'b1;
    assign room2      = (cnt_reg <= (Q_AW + 1)'(QUEUE_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push_a)
            mem[wr_reg] <= cmd_a;
        if (push_b)
            mem[wr_b] <= cmd_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + Q_AW'(push_a) + Q_AW'(push_b);
            rd_reg  <= rd_reg + Q_AW'(do_pop);
            cnt_reg <= cnt_reg + (Q_AW + 1)'(push_a) + (Q_AW + 1)'(push_b)
                       - (Q_AW + 1)'(do_pop);
        end
    end

endmodule

/* src/fes_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_back: frame builder
// Expands queued commands into output bytes and holds the parameter set stores.
// ----------------------------------------------------------------------------
module fes_back
    import fes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    input  adts_cfg_t  cfg,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       frame_last,
    output logic       is_audio,
    output logic       key_frame,
    output logic       store_overflow
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CODE, ST_HDR1, ST_SPS, ST_HDR2, ST_PPS, ST_ADTS
    } state_t;

    localparam int LCMP = CNT_W + 1;

    logic [7:0] sps_mem [SPS_BYTES];
    logic [7:0] pps_mem [PPS_BYTES];

    state_t            st_reg, st_next;
    cmd_t              cur_reg, cur_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SPS_LW-1:0] sps_len_reg, sps_len_next;
    logic [PPS_LW-1:0] pps_len_reg, pps_len_next;
    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic              ol_reg, ol_next;
    logic              oa_reg, oa_next;
    logic              ok_reg, ok_next;
    logic              oo_reg, oo_next;

    logic        can_emit;
    logic        emit;
    logic [7:0]  eb;
    logic        el;
    cmd_t        ef;
    logic [12:0] flen;
    logic        cnt3;
    logic        sps_end, pps_end;
    logic        sps_we, pps_we;

    assign can_emit = !ov_reg || out_ready;
    assign flen     = cur_reg.data[12:0];
    assign cnt3     = (cnt_reg == CNT_W'(3));
    assign sps_end  = (LCMP'(cnt_reg) + LCMP'(1) == LCMP'(sps_len_reg));
    assign pps_end  = (LCMP'(cnt_reg) + LCMP'(1) == LCMP'(pps_len_reg));
    assign sps_we   = (st_reg == ST_IDLE) && head_valid && (head.kind == CMD_SPS_WR);
    assign pps_we   = (st_reg == ST_IDLE) && head_valid && (head.kind == CMD_PPS_WR);

    always_comb
    begin
        st_next      = st_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        sps_len_next = sps_len_reg;
        pps_len_next = pps_len_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        eb           = 8'h00;
        el           = 1'b0;
        ef           = cur_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    ef = head;
                    unique case (head.kind)
                        CMD_BYTE:
                        begin
                            if (can_emit)
                            begin
                                emit = 1'b1;
                                eb   = head.data[7:0];
                                el   = head.last;
                                pop  = 1'b1;
                            end
                        end
                        CMD_START:
                        begin
                            pop = 1'b1; cur_next = head; cnt_next = '0; st_next = ST_CODE;
                        end
                        CMD_SETS:
                        begin
                            pop = 1'b1; cur_next = head; cnt_next = '0; st_next = ST_HDR1;
                        end
                        CMD_ADTS:
                        begin
                            pop = 1'b1; cur_next = head; cnt_next = '0; st_next = ST_ADTS;
                        end
                        CMD_SPS_WR:
                        begin
                            pop = 1'b1;
                            sps_len_next = SPS_LW'(head.data[15:8]) + 1'b1;
                        end
                        CMD_PPS_WR:
                        begin
                            pop = 1'b1;
                            pps_len_next = PPS_LW'(head.data[15:8]) + 1'b1;
                        end
                        CMD_SPS_CLR:
                        begin
                            pop = 1'b1; sps_len_next = '0;
                        end
                        CMD_PPS_CLR:
                        begin
                            pop = 1'b1; pps_len_next = '0;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_CODE, ST_HDR1, ST_HDR2:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    eb   = cnt3 ? 8'h01 : 8'h00;
                    cnt_next = cnt_reg + 1'b1;
                    if (st_reg == ST_CODE)
                        el = cur_reg.last && cnt3;
                    else if (st_reg == ST_HDR2)
                        el = cur_reg.last && cnt3 && (pps_len_reg == '0);
                    if (cnt3)
                    begin
                        cnt_next = '0;
                        if (st_reg == ST_CODE)
                            st_next = ST_IDLE;
                        else if (st_reg == ST_HDR1)
                            st_next = (sps_len_reg != '0) ? ST_SPS : ST_HDR2;
                        else
                            st_next = (pps_len_reg != '0) ? ST_PPS : ST_IDLE;
                    end
                end
            end
            ST_SPS:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    eb   = sps_mem[cnt_reg[SPS_AW-1:0]];
                    cnt_next = cnt_reg + 1'b1;
                    if (sps_end)
                    begin
                        cnt_next = '0;
                        st_next = ST_HDR2;
                    end
                end
            end
            ST_PPS:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    eb   = pps_mem[cnt_reg[PPS_AW-1:0]];
                    el   = cur_reg.last && pps_end;
                    cnt_next = cnt_reg + 1'b1;
                    if (pps_end)
                    begin
                        cnt_next = '0;
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_ADTS:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    case (cnt_reg)
                        CNT_W'(0): eb = 8'hff;
                        CNT_W'(1): eb = 8'hf1;
                        CNT_W'(2): eb = {cfg.profile, cfg.rate_index, 1'b0, cfg.channels[2]};
                        CNT_W'(3): eb = {cfg.channels[1:0], 4'b0000, flen[12:11]};
                        CNT_W'(4): eb = flen[10:3];
                        CNT_W'(5): eb = {flen[2:0], 5'h1f};
                        default:   eb = 8'hfc;
                    endcase
                    el = cur_reg.last && (cnt_reg == CNT_W'(6));
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(6))
                    begin
                        cnt_next = '0;
                        st_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        ov_next = emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
        ob_next = emit ? eb : ob_reg;
        ol_next = emit ? el : ol_reg;
        oa_next = emit ? ef.audio : oa_reg;
        ok_next = emit ? ef.key : ok_reg;
        oo_next = emit ? ef.ovf : oo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sps_we)
            sps_mem[head.data[8 +: SPS_AW]] <= head.data[7:0];
        if (pps_we)
            pps_mem[head.data[8 +: PPS_AW]] <= head.data[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            cnt_reg     <= '0;
            sps_len_reg <= '0;
            pps_len_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            sps_len_reg <= sps_len_next;
            pps_len_reg <= pps_len_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
        oa_reg  <= oa_next;
        ok_reg  <= ok_next;
        oo_reg  <= oo_next;
    end

    assign out_valid      = ov_reg;
    assign out_byte       = ob_reg;
    assign frame_last     = ol_reg;
    assign is_audio       = oa_reg;
    assign key_frame      = ok_reg;
    assign store_overflow = oo_reg;

    // The store readers are only entered with a nonempty store.
    a_sps_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_SPS |-> sps_len_reg != '0)
        else $error("SPS readout with empty store");
    a_pps_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_PPS |-> pps_len_reg != '0)
        else $error("PPS readout with empty store");
    a_sps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sps_len_reg <= SPS_LW'(SPS_BYTES))
        else $error("SPS length beyond store");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

/* src/flv_tag_to_elementary_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_to_elementary_stream: FLV tags to Annex-B video and ADTS audio
// Parses FLV tags byte by byte and emits H.264 Annex-B or AAC ADTS frames.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transaction
//  tag_in    in         one FLV tag byte, tag_last on the final byte of a tag
//  es_out    out        one frame byte with frame_last, is_audio, key_frame,
//                       store_overflow
//  cfg       in         write of ADTS profile, rate index or channel register
//
// The parser takes one tag byte per cycle whenever the command queue has room
// for two entries. The frame builder emits one output byte per cycle while the
// output is not stalled, but fetches a start code, SPS/PPS replay or ADTS
// header command first; a long keyframe header stalls the input once fewer
// than two of the four queue entries are free.
// Reset is asynchronous and active low; the stores hold no valid state and
// are only read below their recorded lengths. Output stalls are absorbed by
// the output register and then the queue; configuration writes are always taken.
module flv_tag_to_elementary_stream
    import fes_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    fes_tag_if.sink    tag_in,
    fes_es_if.source   es_out,
    fes_cfg_if.sink    cfg
);

    adts_cfg_t cfg_reg;

    logic room2, push_a, push_b, head_valid, pop;
    cmd_t cmd_a, cmd_b, head;

    assign cfg.ready = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.profile    <= 2'd1;
            cfg_reg.rate_index <= 4'd3;
            cfg_reg.channels   <= 3'd2;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PROFILE:    cfg_reg.profile    <= cfg.data[1:0];
                REG_RATE_INDEX: cfg_reg.rate_index <= cfg.data;
                REG_CHANNELS:   cfg_reg.channels   <= cfg.data[2:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: tag parser, which also owns the overflow flag.
    fes_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tag_in.valid),
        .in_byte  (tag_in.tag_byte),
        .in_last  (tag_in.tag_last),
        .in_ready (tag_in.ready),
        .room2    (room2),
        .push_a   (push_a),
        .cmd_a    (cmd_a),
        .push_b   (push_b),
        .cmd_b    (cmd_b)
    );

    // Store writes travel through the queue, so a replay never sees a later
    // sequence header.
    fes_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_a     (push_a),
        .cmd_a      (cmd_a),
        .push_b     (push_b),
        .cmd_b      (cmd_b),
        .room2      (room2),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Back end: frame builder with the SPS and PPS stores.
    fes_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .cfg            (cfg_reg),
        .out_ready      (es_out.ready),
        .out_valid      (es_out.valid),
        .out_byte       (es_out.out_byte),
        .frame_last     (es_out.frame_last),
        .is_audio       (es_out.is_audio),
        .key_frame      (es_out.key_frame),
        .store_overflow (es_out.store_overflow)
    );

endmodule

/* bench/flv_tag_to_elementary_stream_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_to_elementary_stream_tb: self-checking bench for the FLV converter
// Feeds FLV tags (AVC sequence headers, video frames, AAC audio, noise and
// truncated tags) through the tag channel with random idling, rebuilds every
// expected Annex-B / ADTS byte in a local parser, and compares each output
// transaction field by field. ADTS registers are rewritten between phases.
// ----------------------------------------------------------------------------
module flv_tag_to_elementary_stream_tb;
    import fes_pkg::*;

    // Parser phases of the local frame predictor.
    typedef enum int {
        FP_HDR, FP_VCODEC, FP_VPTYPE, FP_VCTS, FP_VCFG, FP_VNSPS, FP_VSPSLEN,
        FP_VSPSDATA, FP_VNPPS, FP_VPPSLEN, FP_VPPSDATA, FP_VNLEN, FP_PAYLOAD,
        FP_ACODEC, FP_APTYPE, FP_SKIP
    } frame_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       audio;
        logic       key;
        logic       ovf;
    } es_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } tag_byte_t;

    localparam int MAX_BYTES_PER_STEP = 60;
    localparam int DRAIN_CYCLES       = 40;
    localparam int STALL_LIMIT        = 5000;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int TARGET_ITEMS       = 260;
    localparam int MIN_PHASE_ITEMS    = 16;

    logic clk;
    logic rst_n;

    fes_tag_if tag_in ();
    fes_es_if  es_out ();
    fes_cfg_if cfg ();

    flv_tag_to_elementary_stream i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (tag_in),
        .es_out (es_out),
        .cfg    (cfg)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser, the parameter-set
    // stores and the ADTS registers.
    // ------------------------------------------------------------------
    frame_phase_t fp_phase;
    int           fp_count;
    logic [7:0]   fp_kind;
    logic [23:0]  fp_body_size;
    logic [7:0]   fp_codec;
    logic [7:0]   fp_packet;
    logic [31:0]  fp_nalu_left;
    logic [7:0]   fp_sets_left;
    logic [15:0]  fp_entry_len;
    logic [7:0]   sps_bytes [SPS_BYTES];
    logic [7:0]   pps_bytes [PPS_BYTES];
    int           sps_fill;
    int           pps_fill;
    logic         fp_ovf;
    adts_cfg_t    adts_regs;

    es_byte_t  step_bytes[$];     // output caused by the current tag byte
    es_byte_t  expected_es[$];    // output bytes still to arrive
    tag_byte_t pending_tag[$];    // tag bytes still to be offered
    tag_byte_t body[$];           // scratch body of the tag being built

    int  mismatches;
    bit  idle_enable;
    int  hold_requests;
    int  hold_served;
    int  hold_left;
    bit  accepted_any;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h, want %0h (at %0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // One output byte; bytes beyond the per-step limit are lost.
    task automatic emit(input logic [7:0] b);
        es_byte_t e;
        if (step_bytes.size() >= MAX_BYTES_PER_STEP)
            return;
        e.data  = b;
        e.last  = 1'b0;
        e.audio = (fp_kind == TAG_AUDIO);
        e.key   = !e.audio && (fp_codec[7:4] == FRAME_KEY);
        e.ovf   = fp_ovf;
        step_bytes.push_back(e);
    endtask

    task automatic close_frame();
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size() - 1].last = 1'b1;
    endtask

    task automatic emit_start_code();
        emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h01);
    endtask

    task automatic emit_param_sets();
        emit_start_code();
        for (int i = 0; i < sps_fill; i++)
            emit(sps_bytes[i]);
        emit_start_code();
        for (int i = 0; i < pps_fill; i++)
            emit(pps_bytes[i]);
    endtask

    task automatic sps_entry_done();
        fp_sets_left = fp_sets_left - 8'd1;
        fp_count     = 0;
        fp_phase     = (fp_sets_left != 0) ? FP_VSPSLEN : FP_VNPPS;
    endtask

    // The sequence header frame goes out once the last PPS entry is read.
    task automatic pps_entry_done();
        fp_sets_left = fp_sets_left - 8'd1;
        fp_count     = 0;
        if (fp_sets_left != 0) begin
            fp_phase = FP_VPPSLEN;
        end
        else begin
            emit_param_sets();
            close_frame();
            fp_phase = FP_SKIP;
        end
    endtask

    task automatic open_payload();
        fp_phase = (fp_nalu_left != 0) ? FP_PAYLOAD : FP_SKIP;
        if (fp_nalu_left == 0)
            close_frame();
    endtask

    // Advance the parser by one accepted tag byte and queue what it produces.
    task automatic predict_frame_bytes(input logic [7:0] b, input logic last);
        logic [23:0] aac_len;
        logic [12:0] adts_len;
        step_bytes.delete();
        case (fp_phase)
            FP_HDR: begin
                if (fp_count == 0)
                    fp_kind = b;
                else if (fp_count <= 3)
                    fp_body_size = {fp_body_size[15:0], b};
                fp_count++;
                if (fp_count == 11) begin
                    fp_count = 0;
                    fp_phase = (fp_kind == TAG_VIDEO) ? FP_VCODEC :
                               (fp_kind == TAG_AUDIO) ? FP_ACODEC : FP_SKIP;
                end
            end
            FP_VCODEC: begin
                fp_codec = b;
                fp_phase = (b[3:0] == CODEC_AVC) ? FP_VPTYPE : FP_SKIP;
            end
            FP_VPTYPE: begin
                fp_packet = b;
                fp_count  = 0;
                fp_phase  = FP_VCTS;
            end
            FP_VCTS: begin
                fp_count++;
                if (fp_count == 3) begin
                    fp_count     = 0;
                    fp_nalu_left = '0;
                    if (fp_codec[7:4] == FRAME_KEY)
                        fp_phase = (fp_packet == 0) ? FP_VCFG :
                                   (fp_packet == 1) ? FP_VNLEN : FP_SKIP;
                    else
                        fp_phase = FP_VNLEN;
                end
            end
            FP_VCFG: begin
                fp_count++;
                if (fp_count == 5)
                    fp_phase = FP_VNSPS;
            end
            FP_VNSPS: begin
                fp_sets_left = {3'b000, b[4:0]};
                sps_fill     = 0;
                fp_ovf       = 1'b0;
                fp_count     = 0;
                fp_phase     = (fp_sets_left != 0) ? FP_VSPSLEN : FP_VNPPS;
            end
            FP_VSPSLEN: begin
                fp_entry_len = {fp_entry_len[7:0], b};
                fp_count++;
                if (fp_count == 2) begin
                    if (fp_entry_len != 0)
                        fp_phase = FP_VSPSDATA;
                    else
                        sps_entry_done();
                end
            end
            FP_VSPSDATA: begin
                if (sps_fill < SPS_BYTES)
                    sps_bytes[sps_fill++] = b;
                else
                    fp_ovf = 1'b1;
                fp_entry_len = fp_entry_len - 16'd1;
                if (fp_entry_len == 0)
                    sps_entry_done();
            end
            FP_VNPPS: begin
                fp_sets_left = b;
                pps_fill     = 0;
                fp_count     = 0;
                if (fp_sets_left != 0) begin
                    fp_phase = FP_VPPSLEN;
                end
                else begin
                    fp_sets_left = 8'd1;
                    pps_entry_done();
                end
            end
            FP_VPPSLEN: begin
                fp_entry_len = {fp_entry_len[7:0], b};
                fp_count++;
                if (fp_count == 2) begin
                    if (fp_entry_len != 0)
                        fp_phase = FP_VPPSDATA;
                    else
                        pps_entry_done();
                end
            end
            FP_VPPSDATA: begin
                if (pps_fill < PPS_BYTES)
                    pps_bytes[pps_fill++] = b;
                else
                    fp_ovf = 1'b1;
                fp_entry_len = fp_entry_len - 16'd1;
                if (fp_entry_len == 0)
                    pps_entry_done();
            end
            FP_VNLEN: begin
                fp_nalu_left = {fp_nalu_left[23:0], b};
                fp_count++;
                if (fp_count == 4) begin
                    fp_count = 0;
                    if (fp_codec[7:4] == FRAME_KEY)
                        emit_param_sets();
                    emit_start_code();
                    open_payload();
                end
            end
            FP_PAYLOAD: begin
                emit(b);
                fp_nalu_left = fp_nalu_left - 32'd1;
                if (fp_nalu_left == 0) begin
                    close_frame();
                    fp_phase = FP_SKIP;
                end
            end
            FP_ACODEC: begin
                fp_codec = b;
                fp_phase = (b[7:4] == SOUND_AAC) ? FP_APTYPE : FP_SKIP;
            end
            FP_APTYPE: begin
                fp_packet = b;
                aac_len   = (fp_body_size >= 2) ? fp_body_size - 24'd2 : 24'd0;
                adts_len  = 13'(aac_len + 24'd7);
                emit(8'hff);
                emit(8'hf1);
                emit({adts_regs.profile, adts_regs.rate_index, 1'b0,
                      adts_regs.channels[2]});
                emit({adts_regs.channels[1:0], 4'b0000, adts_len[12:11]});
                emit(adts_len[10:3]);
                emit({adts_len[2:0], 5'h1f});
                emit(8'hfc);
                fp_nalu_left = {8'h00, aac_len};
                open_payload();
            end
            default: fp_phase = FP_SKIP;
        endcase
        // The end of a tag always returns to the header; an open payload is cut.
        if (last) begin
            if (fp_phase == FP_PAYLOAD)
                close_frame();
            fp_phase = FP_HDR;
            fp_count = 0;
        end
        foreach (step_bytes[i])
            expected_es.push_back(step_bytes[i]);
    endtask

    // ------------------------------------------------------------------
    // Tag builders. Each fills body[] and then hands header plus body to
    // the pending queue, optionally cut short or followed by trailing bytes.
    // ------------------------------------------------------------------
    task automatic add_body_byte(input logic [7:0] b);
        tag_byte_t t;
        t.data = b;
        t.last = 1'b0;
        body.push_back(t);
    endtask

    task automatic add_random_bytes(input int count);
        repeat (count) add_body_byte(8'($urandom));
    endtask

    // cut < 0 keeps the whole body; otherwise the tag ends after byte cut.
    task automatic queue_tag(input logic [7:0] kind, input logic [23:0] size,
                             input int cut, input int trailing);
        tag_byte_t t;
        tag_byte_t whole[$];
        t.last = 1'b0;
        t.data = kind;               whole.push_back(t);
        t.data = size[23:16];        whole.push_back(t);
        t.data = size[15:8];         whole.push_back(t);
        t.data = size[7:0];          whole.push_back(t);
        repeat (7) begin
            t.data = 8'($urandom);   // timestamp and stream id
            whole.push_back(t);
        end
        foreach (body[i])
            whole.push_back(body[i]);
        repeat (trailing) begin
            t.data = 8'($urandom);
            whole.push_back(t);
        end
        if (cut >= 0 && cut < whole.size() - 1)
            whole = whole[0:cut];
        whole[whole.size() - 1].last = 1'b1;
        foreach (whole[i])
            pending_tag.push_back(whole[i]);
        body.delete();
    endtask

    task automatic add_param_entries(input int count, input int total);
        int len;
        for (int i = 0; i < count; i++) begin
            len = (i == count - 1) ? total : $urandom_range(0, total);
            total -= len;
            add_body_byte(8'(len >> 8));
            add_body_byte(8'(len));
            add_random_bytes(len);
        end
    endtask

    task automatic build_seq_header(input int n_sps, input int sps_total,
                                    input int n_pps, input int pps_total,
                                    input int cut);
        add_body_byte({FRAME_KEY, CODEC_AVC});
        add_body_byte(8'h00);
        add_random_bytes(3);         // composition time
        add_random_bytes(5);         // configuration record head
        add_body_byte({3'($urandom), 5'(n_sps)});
        add_param_entries(n_sps, sps_total);
        add_body_byte(8'(n_pps));
        add_param_entries(n_pps, pps_total);
        queue_tag(TAG_VIDEO, 24'(body.size()), cut, 0);
    endtask

    task automatic build_video_frame(input logic [7:0] codec, input logic [7:0] packet,
                                     input logic [31:0] nalu_len, input int payload,
                                     input int cut, input int trailing);
        add_body_byte(codec);
        add_body_byte(packet);
        add_random_bytes(3);
        add_body_byte(nalu_len[31:24]);
        add_body_byte(nalu_len[23:16]);
        add_body_byte(nalu_len[15:8]);
        add_body_byte(nalu_len[7:0]);
        add_random_bytes(payload);
        queue_tag(TAG_VIDEO, 24'(body.size()), cut, trailing);
    endtask

    task automatic build_audio(input logic [7:0] codec, input logic [23:0] size,
                               input int payload, input int cut);
        add_body_byte(codec);
        add_body_byte(8'($urandom));
        add_random_bytes(payload);
        queue_tag(TAG_AUDIO, size, cut, 0);
    endtask

    task automatic build_random_tag();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            build_seq_header($urandom_range(0, 3), $urandom_range(0, 40),
                             $urandom_range(0, 2), $urandom_range(0, 20),
                             ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : -1);
        end
        else if (pick < 45) begin
            len = $urandom_range(0, 12);
            build_video_frame({($urandom_range(0, 1) != 0) ? FRAME_KEY : 4'h2, CODEC_AVC},
                              ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd1,
                              ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'(len),
                              len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 25) : -1,
                              $urandom_range(0, 2));
        end
        else if (pick < 80) begin
            len = $urandom_range(0, 12);
            build_audio({SOUND_AAC, 4'($urandom)},
                        ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'(len + 2),
                        len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : -1);
        end
        else if (pick < 90) begin
            // Unknown tag types and codecs only get skipped.
            add_random_bytes($urandom_range(0, 6));
            queue_tag(($urandom_range(0, 1) != 0) ? 8'($urandom) : TAG_VIDEO,
                      24'($urandom), -1, 0);
        end
        else begin
            // Raw noise with random tag ends.
            repeat ($urandom_range(1, 8)) begin
                tag_byte_t t;
                t.data = 8'($urandom);
                t.last = ($urandom_range(0, 3) == 0);
                pending_tag.push_back(t);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tag driver: offers pending bytes, holds them while the block stalls,
    // and inserts random idle bursts while idling is enabled.
    // ------------------------------------------------------------------
    int tag_gap;

    always @(posedge clk or negedge rst_n) begin
        tag_byte_t next_byte;
        if (!rst_n) begin
            tag_in.valid    <= 1'b0;
            tag_in.tag_byte <= '0;
            tag_in.tag_last <= 1'b0;
            tag_gap         = 0;
        end
        else begin
            if (tag_in.valid && tag_in.ready)
                predict_frame_bytes(tag_in.tag_byte, tag_in.tag_last);
            // A byte that was offered but not taken stays on the bus.
            if (!(tag_in.valid && !tag_in.ready)) begin
                if (tag_gap > 0) begin
                    tag_gap--;
                    tag_in.valid <= 1'b0;
                end
                else if (idle_enable && $urandom_range(0, 7) == 0) begin
                    tag_gap = $urandom_range(0, 2);
                    tag_in.valid <= 1'b0;
                end
                else if (pending_tag.size() > 0) begin
                    next_byte = pending_tag.pop_front();
                    tag_in.valid    <= 1'b1;
                    tag_in.tag_byte <= next_byte.data;
                    tag_in.tag_last <= next_byte.last;
                end
                else begin
                    tag_in.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps going meanwhile.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD_CYCLES;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each transaction against the oldest expected
    // byte and drives ready with random stall bursts.
    // ------------------------------------------------------------------
    int es_stall;

    always @(posedge clk or negedge rst_n) begin
        es_byte_t want;
        if (!rst_n) begin
            es_out.ready <= 1'b0;
            es_stall     = 0;
        end
        else begin
            if (es_out.valid && es_out.ready) begin
                if (expected_es.size() == 0) begin
                    report_mismatch("unexpected byte", es_out.out_byte, 0);
                end
                else begin
                    want = expected_es.pop_front();
                    if (es_out.out_byte !== want.data)
                        report_mismatch("out_byte", es_out.out_byte, want.data);
                    if (es_out.frame_last !== want.last)
                        report_mismatch("frame_last", es_out.frame_last, want.last);
                    if (es_out.is_audio !== want.audio)
                        report_mismatch("is_audio", es_out.is_audio, want.audio);
                    if (es_out.key_frame !== want.key)
                        report_mismatch("key_frame", es_out.key_frame, want.key);
                    if (es_out.store_overflow !== want.ovf)
                        report_mismatch("store_overflow", es_out.store_overflow, want.ovf);
                end
            end
            if (hold_left > 0) begin
                es_out.ready <= 1'b0;
            end
            else if (es_stall > 0) begin
                es_stall--;
                es_out.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 6) == 0) begin
                es_stall = $urandom_range(0, 2);
                es_out.ready <= 1'b0;
            end
            else begin
                es_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    int stall_cycles;

    always @(posedge clk) begin
        if ((tag_in.valid && tag_in.ready) || (es_out.valid && es_out.ready)
                || (cfg.valid && cfg.ready) || !rst_n) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes and phase sequencing.
    // ------------------------------------------------------------------
    task automatic write_register(input logic [1:0] index, input logic [3:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (index)
            REG_PROFILE:    adts_regs.profile    = value[1:0];
            REG_RATE_INDEX: adts_regs.rate_index = value;
            REG_CHANNELS:   adts_regs.channels   = value[2:0];
            default: ;
        endcase
    endtask

    task automatic write_adts(input logic [1:0] profile, input logic [3:0] rate,
                              input logic [2:0] channels);
        write_register(REG_PROFILE, {2'b00, profile});
        write_register(REG_RATE_INDEX, rate);
        write_register(REG_CHANNELS, {1'b0, channels});
    endtask

    // Waits until every tag byte is taken and every output byte has arrived;
    // tags that produce nothing may still be in flight, so drain a little more.
    task automatic wait_until_idle();
        @(posedge clk);
        while (pending_tag.size() > 0 || tag_in.valid || expected_es.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_tags(input int items);
        int goal;
        goal = pending_tag.size() + items;
        while (pending_tag.size() < goal)
            build_random_tag();
    endtask

    initial begin
        int directed_items;
        int phase_items;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg.valid    = 1'b0;
        cfg.index    = REG_PROFILE;
        cfg.data     = '0;
        tag_in.valid = 1'b0;
        es_out.ready = 1'b0;
        mismatches   = 0;
        idle_enable  = 1'b1;
        hold_requests = 0;
        stall_cycles = 0;

        // Reset values of the predictor match the block after reset.
        fp_phase     = FP_HDR;
        fp_count     = 0;
        fp_kind      = '0;
        fp_body_size = '0;
        fp_codec     = '0;
        fp_packet    = '0;
        fp_nalu_left = '0;
        fp_sets_left = '0;
        fp_entry_len = '0;
        sps_fill     = 0;
        pps_fill     = 0;
        fp_ovf       = 1'b0;
        adts_regs.profile    = 2'd1;
        adts_regs.rate_index = 4'd3;
        adts_regs.channels   = 3'd2;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset ADTS settings, with a long output
        // hold-off while the tags pile up.
        hold_requests = 1;
        // A keyframe before any sequence header replays empty stores.
        build_video_frame({FRAME_KEY, CODEC_AVC}, 8'd1, 32'd2, 2, -1, 0);
        // Sequence header with no SPS and no PPS entries at all.
        build_seq_header(0, 0, 0, 0, -1);
        // Store overflow on both stores, then a keyframe replaying them.
        build_seq_header(2, 40, 2, 20, -1);
        build_video_frame({FRAME_KEY, CODEC_AVC}, 8'd1, 32'd0, 0, -1, 0);
        // Zero-length entries and a sequence header cut short.
        build_seq_header(3, 0, 1, 3, -1);
        build_seq_header(1, 6, 1, 4, 20);
        // Inter frame with a payload longer than the NALU, and a cut payload.
        build_video_frame({4'h2, CODEC_AVC}, 8'hff, 32'd3, 6, -1, 2);
        build_video_frame({4'h2, CODEC_AVC}, 8'd1, 32'hffff_ffff, 8, 22, 0);
        // Keyframe with an unknown packet type, a non-AVC codec, unknown tag.
        build_video_frame({FRAME_KEY, CODEC_AVC}, 8'd2, 32'd1, 1, -1, 0);
        build_video_frame({FRAME_KEY, 4'h2}, 8'd1, 32'd1, 1, -1, 0);
        add_random_bytes(3);
        queue_tag(8'h12, 24'hffffff, -1, 0);
        // Audio: short bodies, a huge body size and a non-AAC codec.
        build_audio({SOUND_AAC, 4'hf}, 24'd0, 0, -1);
        build_audio({SOUND_AAC, 4'h0}, 24'd1, 0, -1);
        build_audio({SOUND_AAC, 4'h5}, 24'hffffff, 4, 16);
        build_audio({4'h2, 4'h5}, 24'd5, 3, -1);
        directed_items = pending_tag.size();
        phase_items = (TARGET_ITEMS - directed_items) / 3;
        if (phase_items < MIN_PHASE_ITEMS)
            phase_items = MIN_PHASE_ITEMS;
        wait_until_idle();

        // All-zero registers.
        write_adts(2'd0, 4'd0, 3'd0);
        run_random_tags(phase_items);
        wait_until_idle();

        // All-ones registers.
        write_adts(2'd3, 4'd15, 3'd7);
        run_random_tags(phase_items);
        wait_until_idle();

        // Random registers; the last part runs with no idling at all.
        write_adts(2'($urandom), 4'($urandom), 3'($urandom));
        idle_enable = 1'b0;
        run_random_tags(phase_items);
        wait_until_idle();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
